>>> rtl/core/mf2c_pkg.sv
// Shared constants, register indexes and controller/datapath interface types
// for the clamped 2-D median filter. No dependencies.
package mf2c_pkg;

    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int DATA_W  = 16;  // sample width
    localparam int CFG_W   = 11;  // width/height register width
    localparam int RAD_W   = 2;   // radius register width
    localparam int COORD_W = 10;  // out_row / out_col width
    localparam int DIM_W   = 13;  // internal coordinate width, holds up to 8191
    localparam int OFF_W   = 4;   // signed window offset, -8..7
    localparam int IDX_W   = 2;   // config index width

    localparam logic [IDX_W-1:0] REG_IMG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS     = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMG_WIDTH  = 11'd64;
    localparam logic [CFG_W-1:0] RST_IMG_HEIGHT = 11'd64;
    localparam logic [RAD_W-1:0] RST_RADIUS     = 2'd1;

    typedef struct packed {
        logic start_item;  // item accepted: store sample, set output range
        logic win_start;   // begin gathering one window
        logic rd_issue;    // issue one line store read
        logic rotate;      // rank one candidate, rotate window
        logic next_out;    // result taken, step to next output pixel
    } mf2c_cmd_t;

    typedef struct packed {
        logic no_out;      // current item produces no result
        logic rd_last;     // this read is the last of the window
        logic sort_done;   // this rotation is the last one
        logic last_out;    // current output is the last of the item
    } mf2c_sts_t;

endpackage

>>> rtl/core/mf2c_ctrl.sv
// Sequencing state machine for the median filter.
// Depends on mf2c_pkg (command/status types).
module mf2c_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mf2c_pkg::mf2c_sts_t   sts,
    output mf2c_pkg::mf2c_cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_WIN   = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_FLUSH = 8'b0001_0000,
        S_SORT  = 8'b0010_0000,
        S_PICK  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_CHECK;
            S_CHECK: state_next = sts.no_out ? S_IDLE : S_WIN;
            S_WIN:   state_next = S_READ;
            S_READ:  if (sts.rd_last) state_next = S_FLUSH;
            S_FLUSH: state_next = S_SORT;
            S_SORT:  if (sts.sort_done) state_next = S_PICK;
            S_PICK:  state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = sts.last_out ? S_IDLE : S_WIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign cmd.start_item = (state_reg == S_IDLE) && in_valid;
    assign cmd.win_start  = (state_reg == S_WIN);
    assign cmd.rd_issue   = (state_reg == S_READ);
    assign cmd.rotate     = (state_reg == S_SORT);
    assign cmd.next_out   = (state_reg == S_OUT) && out_ready;

endmodule

>>> rtl/core/mf2c_datapath.sv
// Line store, counters, window gather and rank-select median unit.
// Depends on mf2c_pkg; driven by mf2c_ctrl through command/status structs.
module mf2c_datapath
#(
    parameter int MAX_RADIUS = mf2c_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = mf2c_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf2c_pkg::DEF_MAX_HEIGHT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mf2c_pkg::IDX_W-1:0]            cfg_index,
    input  logic [mf2c_pkg::CFG_W-1:0]            cfg_data,
    input  logic signed [mf2c_pkg::DATA_W-1:0]    sample,
    input  mf2c_pkg::mf2c_cmd_t                   cmd,
    output mf2c_pkg::mf2c_sts_t                   sts,
    output logic signed [mf2c_pkg::DATA_W-1:0]    median,
    output logic [mf2c_pkg::COORD_W-1:0]          out_row,
    output logic [mf2c_pkg::COORD_W-1:0]          out_col,
    output logic                                  last
);

    localparam int DW    = mf2c_pkg::DIM_W;
    localparam int OW    = mf2c_pkg::OFF_W;
    localparam int XW    = mf2c_pkg::DATA_W;
    localparam int RING  = 2 * MAX_RADIUS + 1;
    localparam int WMAX  = RING * RING;
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (RING > 1) ? $clog2(RING) : 1;
    localparam int CW    = $clog2(WMAX + 1);

    // configuration
    logic [mf2c_pkg::CFG_W-1:0] width_reg;
    logic [mf2c_pkg::CFG_W-1:0] height_reg;
    logic [mf2c_pkg::RAD_W-1:0] radius_reg;

    // raster position of the next sample
    logic [DW-1:0] row_reg;
    logic [DW-1:0] col_reg;
    logic [SW-1:0] slot_reg;

    // per item
    logic [DW-1:0] y_reg;
    logic [SW-1:0] islot_reg;
    logic [DW-1:0] r1_reg;
    logic [DW-1:0] c0_reg;
    logic [DW-1:0] c1_reg;
    logic [DW-1:0] oy_reg;
    logic [DW-1:0] ox_reg;
    logic          no_out_reg;

    // window gather
    logic signed [OW-1:0] dy_reg;
    logic signed [OW-1:0] dx_reg;
    logic                 rd_vld_reg;
    logic signed [XW-1:0] rdata_reg;
    logic signed [XW-1:0] mem [DEPTH];
    logic signed [XW-1:0] win_reg [WMAX];
    logic [WMAX-1:0]      wv_reg;

    // rank select
    logic [CW-1:0]        rot_reg;
    logic                 chk_v_reg;
    logic                 cand_v_reg;
    logic signed [XW-1:0] cand_reg;
    logic [CW-1:0]        lt_reg;
    logic [CW-1:0]        le_reg;
    logic signed [XW-1:0] med_reg;

    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [OW-1:0] r_eff;
    logic [DW-1:0] r_dim;
    logic signed [OW-1:0] r_s;
    logic [CW-1:0] k_rank;

    logic [DW-1:0] y_cur;
    logic [DW-1:0] x_cur;
    logic [SW-1:0] slot_cur;
    logic          last_col;
    logic          last_row;
    logic [AW-1:0] wr_addr;

    logic signed [DW:0] sy;
    logic signed [DW:0] sx;
    logic [DW-1:0]      yy;
    logic [DW-1:0]      xx;
    logic [DW-1:0]      d_full;
    logic [SW:0]        s_wide;
    logic [AW-1:0]      rd_addr;

    logic [CW-1:0] lt;
    logic [CW-1:0] le;

    // effective sizes: zero acts as one, oversize clips
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DW'(1);
        else if (DW'(width_reg) > DW'(MAX_WIDTH))
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = DW'(width_reg);
        if (height_reg == '0)
            h_eff = DW'(1);
        else if (DW'(height_reg) > DW'(MAX_HEIGHT))
            h_eff = DW'(MAX_HEIGHT);
        else
            h_eff = DW'(height_reg);
        r_eff  = (OW'(radius_reg) > OW'(MAX_RADIUS)) ? OW'(MAX_RADIUS) : OW'(radius_reg);
        r_dim  = DW'(r_eff);
        r_s    = $signed(r_eff);
        k_rank = CW'(2 * int'(r_eff) * (int'(r_eff) + 1));
    end

    // item acceptance
    always_comb
    begin
        y_cur    = (row_reg >= h_eff) ? '0 : row_reg;
        slot_cur = (row_reg >= h_eff) ? '0 : slot_reg;
        x_cur    = (col_reg >= w_eff) ? '0 : col_reg;
        last_col = (x_cur == w_eff - DW'(1));
        last_row = (y_cur == h_eff - DW'(1));
        wr_addr  = AW'(int'(slot_cur) * MAX_WIDTH) + AW'(x_cur);
    end

    // window read address: clamp, then ring slot relative to the newest row
    always_comb
    begin
        sy = $signed({1'b0, oy_reg}) + (DW+1)'(dy_reg);
        sx = $signed({1'b0, ox_reg}) + (DW+1)'(dx_reg);
        if (sy < 0)
            yy = '0;
        else if (sy > $signed({1'b0, h_eff - DW'(1)}))
            yy = h_eff - DW'(1);
        else
            yy = sy[DW-1:0];
        if (sx < 0)
            xx = '0;
        else if (sx > $signed({1'b0, w_eff - DW'(1)}))
            xx = w_eff - DW'(1);
        else
            xx = sx[DW-1:0];
        d_full = y_reg - yy;
        if ({1'b0, islot_reg} >= {1'b0, d_full[SW-1:0]})
            s_wide = {1'b0, islot_reg} - {1'b0, d_full[SW-1:0]};
        else
            s_wide = {1'b0, islot_reg} + (SW+1)'(RING) - {1'b0, d_full[SW-1:0]};
        rd_addr = AW'(int'(s_wide[SW-1:0]) * MAX_WIDTH) + AW'(xx);
    end

    // rank of window head against the whole window
    always_comb
    begin
        lt = '0;
        le = '0;
        for (int j = 0; j < WMAX; j++)
        begin
            if (wv_reg[j] && (win_reg[j] < win_reg[0]))
                lt = lt + CW'(1);
            if (wv_reg[j] && (win_reg[j] <= win_reg[0]))
                le = le + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_item)
            mem[wr_addr] <= sample;
        if (cmd.rd_issue)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mf2c_pkg::RST_IMG_WIDTH;
            height_reg <= mf2c_pkg::RST_IMG_HEIGHT;
            radius_reg <= mf2c_pkg::RST_RADIUS;
            row_reg    <= '0;
            col_reg    <= '0;
            slot_reg   <= '0;
            no_out_reg <= 1'b1;
            rd_vld_reg <= 1'b0;
            chk_v_reg  <= 1'b0;
            wv_reg     <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_issue;
            chk_v_reg  <= cmd.rotate;
            if (cfg_we)
            begin
                case (cfg_index)
                    mf2c_pkg::REG_IMG_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        row_reg   <= '0;
                        col_reg   <= '0;
                        slot_reg  <= '0;
                    end
                    mf2c_pkg::REG_IMG_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        row_reg    <= '0;
                        col_reg    <= '0;
                        slot_reg   <= '0;
                    end
                    mf2c_pkg::REG_RADIUS:
                    begin
                        radius_reg <= cfg_data[mf2c_pkg::RAD_W-1:0];
                        row_reg    <= '0;
                        col_reg    <= '0;
                        slot_reg   <= '0;
                    end
                    default: ;
                endcase
            end
            else if (cmd.start_item)
            begin
                no_out_reg <= !((last_row || (y_cur >= r_dim)) &&
                                (last_col || (x_cur >= r_dim)));
                if (last_col)
                begin
                    col_reg <= '0;
                    if (last_row)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= y_cur + DW'(1);
                        slot_reg <= (slot_cur == SW'(RING - 1)) ? '0 : slot_cur + SW'(1);
                    end
                end
                else
                begin
                    col_reg  <= x_cur + DW'(1);
                    row_reg  <= y_cur;
                    slot_reg <= slot_cur;
                end
            end
            if (cmd.win_start)
                wv_reg <= '0;
            else if (rd_vld_reg)
                wv_reg <= {1'b1, wv_reg[WMAX-1:1]};
            else if (cmd.rotate)
                wv_reg <= {wv_reg[0], wv_reg[WMAX-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_item)
        begin
            y_reg     <= y_cur;
            islot_reg <= slot_cur;
            oy_reg    <= (y_cur >= r_dim) ? y_cur - r_dim : '0;
            r1_reg    <= last_row ? y_cur : y_cur - r_dim;
            c0_reg    <= (x_cur >= r_dim) ? x_cur - r_dim : '0;
            ox_reg    <= (x_cur >= r_dim) ? x_cur - r_dim : '0;
            c1_reg    <= last_col ? x_cur : x_cur - r_dim;
        end
        else if (cmd.next_out)
        begin
            if (ox_reg == c1_reg)
            begin
                ox_reg <= c0_reg;
                oy_reg <= oy_reg + DW'(1);
            end
            else
                ox_reg <= ox_reg + DW'(1);
        end

        if (cmd.win_start)
        begin
            dy_reg  <= -r_s;
            dx_reg  <= -r_s;
            rot_reg <= '0;
        end
        else if (cmd.rd_issue)
        begin
            if (dx_reg == r_s)
            begin
                dx_reg <= -r_s;
                dy_reg <= dy_reg + OW'(1);
            end
            else
                dx_reg <= dx_reg + OW'(1);
        end
        else if (cmd.rotate)
            rot_reg <= rot_reg + CW'(1);

        if (rd_vld_reg)
        begin
            for (int i = 0; i < WMAX - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[WMAX-1] <= rdata_reg;
        end
        else if (cmd.rotate)
        begin
            for (int i = 0; i < WMAX - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[WMAX-1] <= win_reg[0];
        end

        if (cmd.rotate)
        begin
            cand_reg   <= win_reg[0];
            cand_v_reg <= wv_reg[0];
            lt_reg     <= lt;
            le_reg     <= le;
        end
        // median: fewer than k+1 below it, more than k at or below it
        if (chk_v_reg && cand_v_reg && (lt_reg <= k_rank) && (le_reg > k_rank))
            med_reg <= cand_reg;
    end

    assign sts.no_out    = no_out_reg;
    assign sts.rd_last   = (dy_reg == r_s) && (dx_reg == r_s);
    assign sts.sort_done = (rot_reg == CW'(WMAX - 1));
    assign sts.last_out  = (oy_reg == r1_reg) && (ox_reg == c1_reg);

    assign median  = med_reg;
    assign out_row = oy_reg[mf2c_pkg::COORD_W-1:0];
    assign out_col = ox_reg[mf2c_pkg::COORD_W-1:0];
    assign last    = sts.last_out;

endmodule

>>> rtl/core/median_filter_2d_clamped.sv
// Clamped-border 2-D median filter, (2r+1)x(2r+1) window, raster input.
// Flow: an item is taken, then its output range is found; each result then needs
// n line store reads (n = (2r+1)^2, one read port) and a flush, then rank selection
// over all WMAX = (2*MAX_RADIUS+1)^2 window slots, then the result is offered.
// One item at a time; an item with no result returns the block to idle after the range check.
// Reset: async active low; counters zero, registers to 64/64/1; line store not cleared.
module median_filter_2d_clamped
#(
    parameter int MAX_RADIUS = mf2c_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = mf2c_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf2c_pkg::DEF_MAX_HEIGHT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [mf2c_pkg::DATA_W-1:0]  sample,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mf2c_pkg::DATA_W-1:0]  median,
    output logic [mf2c_pkg::COORD_W-1:0]        out_row,
    output logic [mf2c_pkg::COORD_W-1:0]        out_col,
    output logic                                last,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf2c_pkg::IDX_W-1:0]          cfg_index,
    input  logic [mf2c_pkg::CFG_W-1:0]          cfg_data
);

    mf2c_pkg::mf2c_cmd_t cmd;
    mf2c_pkg::mf2c_sts_t sts;

    // Config writes are taken only while idle with no item being offered,
    // so a write never lands on an item in flight.
    assign cfg_ready = in_ready && !in_valid;

    // Controller: walks each item through range check, window gather,
    // rank selection and result hand-off.
    mf2c_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: ring of 2*MAX_RADIUS+1 line buffers, raster counters,
    // clamped address generation and the median unit.
    mf2c_datapath
    #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .sts       (sts),
        .median    (median),
        .out_row   (out_row),
        .out_col   (out_col),
        .last      (last)
    );

    // Input and output sides are never open together.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid both high");

    // An accepted item always blocks the next one: in_ready is low in the cycle after acceptance.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted back to back");

    // The last result of an item returns the block to idle.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("not idle after last result");

    // A non-final result is followed by a new window gather, not another result.
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> (!out_valid && cmd.win_start))
        else $error("missing window gather after result");

endmodule

>>> sim/median_filter_2d_clamped_tb.sv
// Self-checking testbench for the clamped-border 2-D median filter.
// Depends on mf2c_pkg and median_filter_2d_clamped; a scoreboard class predicts each result item.
`timescale 1ns / 1ps

module median_filter_2d_clamped_tb;

    localparam int RING     = 2 * mf2c_pkg::DEF_MAX_RADIUS + 1;
    localparam int N_RANDOM = 370;
    // index 3 maps to no register; a write there must change nothing
    localparam logic [mf2c_pkg::IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct {
        logic signed [mf2c_pkg::DATA_W-1:0]  median;
        logic        [mf2c_pkg::COORD_W-1:0] row;
        logic        [mf2c_pkg::COORD_W-1:0] col;
        logic                                last;
    } pixel_out_t;

    // Scoreboard: own copy of line store, counters and registers.
    class median_scoreboard;
        logic signed [mf2c_pkg::DATA_W-1:0] lines [RING*mf2c_pkg::DEF_MAX_WIDTH];
        int unsigned row_pos, col_pos;
        logic [mf2c_pkg::CFG_W-1:0] width_reg, height_reg;
        logic [mf2c_pkg::RAD_W-1:0] radius_reg;
        pixel_out_t pending [$];
        int errors;

        function new();
            foreach (lines[i]) lines[i] = '0;
            row_pos = 0;
            col_pos = 0;
            width_reg = mf2c_pkg::RST_IMG_WIDTH;
            height_reg = mf2c_pkg::RST_IMG_HEIGHT;
            radius_reg = mf2c_pkg::RST_RADIUS;
            errors = 0;
        endfunction

        function int eff(int v, int maxv);
            if (v == 0) return 1;
            return (v > maxv) ? maxv : v;
        endfunction

        function void write_reg(logic [mf2c_pkg::IDX_W-1:0] idx,
                                logic [mf2c_pkg::CFG_W-1:0] data);
            case (idx)
                mf2c_pkg::REG_IMG_WIDTH:  width_reg = data;
                mf2c_pkg::REG_IMG_HEIGHT: height_reg = data;
                mf2c_pkg::REG_RADIUS:     radius_reg = data[mf2c_pkg::RAD_W-1:0];
                default:                  return;
            endcase
            row_pos = 0;
            col_pos = 0;
        endfunction

        function int clampc(int v, int hi);
            return (v < 0) ? 0 : ((v > hi) ? hi : v);
        endfunction

        function int window_median(int oy, int ox, int w, int h, int r);
            int win [RING*RING];
            int n, yy, xx, key, j;
            n = 0;
            for (int dy = -r; dy <= r; dy++) begin
                yy = clampc(oy + dy, h - 1);
                for (int dx = -r; dx <= r; dx++) begin
                    xx = clampc(ox + dx, w - 1);
                    win[n] = int'(lines[(yy % RING) * mf2c_pkg::DEF_MAX_WIDTH + xx]);
                    n++;
                end
            end
            for (int i = 1; i < n; i++) begin
                key = win[i];
                j = i - 1;
                while (j >= 0 && win[j] > key) begin
                    win[j+1] = win[j];
                    j--;
                end
                win[j+1] = key;
            end
            return win[n/2];
        endfunction

        // accepted input item: store it and queue the results it causes
        function void note_input(logic signed [mf2c_pkg::DATA_W-1:0] s);
            int w, h, r, y, x, r0, r1, c0, c1;
            pixel_out_t p;
            w = eff(width_reg, mf2c_pkg::DEF_MAX_WIDTH);
            h = eff(height_reg, mf2c_pkg::DEF_MAX_HEIGHT);
            r = (radius_reg > mf2c_pkg::DEF_MAX_RADIUS) ? mf2c_pkg::DEF_MAX_RADIUS
                                                        : int'(radius_reg);
            if (col_pos >= w) col_pos = 0;
            if (row_pos >= h) row_pos = 0;
            y = row_pos;
            x = col_pos;
            lines[(y % RING) * mf2c_pkg::DEF_MAX_WIDTH + x] = s;
            if (y == h - 1) begin r0 = (y >= r) ? y - r : 0; r1 = y; end
            else if (y >= r) begin r0 = y - r; r1 = y - r; end
            else begin r0 = 0; r1 = -1; end
            if (x == w - 1) begin c0 = (x >= r) ? x - r : 0; c1 = x; end
            else if (x >= r) begin c0 = x - r; c1 = x - r; end
            else begin c0 = 0; c1 = -1; end
            for (int oy = r0; oy <= r1; oy++)
                for (int ox = c0; ox <= c1; ox++) begin
                    p.median = mf2c_pkg::DATA_W'(window_median(oy, ox, w, h, r));
                    p.row = mf2c_pkg::COORD_W'(oy);
                    p.col = mf2c_pkg::COORD_W'(ox);
                    p.last = (oy == r1 && ox == c1);
                    pending.push_back(p);
                end
            if (x == w - 1) begin
                col_pos = 0;
                row_pos = (y == h - 1) ? 0 : y + 1;
            end
            else
                col_pos = x + 1;
        endfunction

        function void check(logic signed [mf2c_pkg::DATA_W-1:0] m,
                            logic [mf2c_pkg::COORD_W-1:0] rw,
                            logic [mf2c_pkg::COORD_W-1:0] cl, logic lst);
            pixel_out_t e;
            if (pending.size() == 0) begin
                if (errors < 10)
                    $display("ERROR: unexpected result median=%0d row=%0d col=%0d last=%0b",
                             m, rw, cl, lst);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (m !== e.median || rw !== e.row || cl !== e.col || lst !== e.last) begin
                if (errors < 10)
                    $display("ERROR: exp median=%0d row=%0d col=%0d last=%0b, got %0d %0d %0d %0b",
                             e.median, e.row, e.col, e.last, m, rw, cl, lst);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [mf2c_pkg::DATA_W-1:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [mf2c_pkg::DATA_W-1:0] median;
    logic [mf2c_pkg::COORD_W-1:0] out_row, out_col;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mf2c_pkg::IDX_W-1:0] cfg_index = '0;
    logic [mf2c_pkg::CFG_W-1:0] cfg_data = '0;

    median_scoreboard sb = new();

    int tx_idle = 24;         // percent of cycles the sender holds off
    int rx_idle = 58;         // percent of cycles the receiver holds off
    bit hold_req = 1'b0;      // ask receiver for one long back-pressure stretch

    always #6 clk = ~clk;

    median_filter_2d_clamped u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready), .median(median),
        .out_row(out_row), .out_col(out_col), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Receiver: random ready, plus a long hold when asked (counted here).
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold == 0)
            begin
                hold = 3000;
                hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                out_ready = 1'b0;
                hold--;
            end
            else
                out_ready = ($urandom_range(99) >= rx_idle);
        end
    end

    // Result monitor, sampled at the rising edge.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check(median, out_row, out_col, last);

    // Offer one input item; called at a falling edge, returns at one.
    // Valid is only dropped in the idle loop, so back-to-back items keep it high.
    task automatic send_pixel(logic signed [mf2c_pkg::DATA_W-1:0] s);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample = s;
        do @(posedge clk); while (!in_ready);
        sb.note_input(s);
        @(negedge clk);
    endtask

    // Wait until every expected result is out, then let a no-result item finish.
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Register write; only issued with the block idle.
    task automatic reg_write(logic [mf2c_pkg::IDX_W-1:0] idx,
                             logic [mf2c_pkg::CFG_W-1:0] data);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_shape(logic [mf2c_pkg::CFG_W-1:0] w, logic [mf2c_pkg::CFG_W-1:0] h,
                             logic [mf2c_pkg::RAD_W-1:0] r);
        reg_write(mf2c_pkg::REG_IMG_WIDTH, w);
        reg_write(mf2c_pkg::REG_IMG_HEIGHT, h);
        reg_write(mf2c_pkg::REG_RADIUS, r);
    endtask

    function automatic logic signed [mf2c_pkg::DATA_W-1:0] rand_pixel();
        case ($urandom_range(3))
            0:       return mf2c_pkg::DATA_W'($urandom_range(7) - 4);   // many ties
            1:       return ($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
            default: return mf2c_pkg::DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [mf2c_pkg::CFG_W-1:0] rand_dim();
        case ($urandom_range(11))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2047;   // above the maximum
            default: return mf2c_pkg::CFG_W'($urandom_range(10, 2));
        endcase
    endfunction

    initial
    begin
        int sent, planes, eff_w, eff_h, n_items;
        bit pressed;
        logic [mf2c_pkg::CFG_W-1:0] w, h;
        logic [mf2c_pkg::RAD_W-1:0] r;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: 3x3 plane, r=1, extreme samples.
        set_shape(11'd3, 11'd3, 2'd1);
        send_pixel(16'sh8000); send_pixel(16'sh7FFF); send_pixel(16'sh0000);
        send_pixel(-16'sd1);   send_pixel(16'sd1);    send_pixel(16'sh7FFF);
        send_pixel(16'sh8000); send_pixel(16'sh5555); send_pixel(16'shAAAA);
        // Zero size acts as 1x1; radius exceeds the plane.
        set_shape(11'd0, 11'd0, 2'd3);
        send_pixel(16'sh1234); send_pixel(16'sh8000);
        // Unmapped index must not restart the plane.
        reg_write(REG_NONE, 11'h7FF);
        send_pixel(16'sh7FFF);
        // Oversize width, r=0: every pixel gives its own result.
        set_shape(11'd2047, 11'd1, 2'd0);
        send_pixel(16'sh0F0F); send_pixel(16'shF0F0); send_pixel(16'sh8000);
        // Oversize height, single column, r=2.
        set_shape(11'd1, 11'd2047, 2'd2);
        repeat (6) send_pixel(rand_pixel());
        // Plane smaller than the window in both directions.
        set_shape(11'd2, 11'd4, 2'd3);
        repeat (8) send_pixel(rand_pixel());

        // Random planes: mostly whole planes, some cut short by a reconfig.
        sent = 0;
        pressed = 1'b0;
        while (sent < N_RANDOM)
        begin
            if (sent < N_RANDOM / 3)          begin tx_idle = 24; rx_idle = 58; end
            else if (sent < 2 * N_RANDOM / 3) begin tx_idle = 58; rx_idle = 24; end
            else                              begin tx_idle = 0;  rx_idle = 0;  end
            w = rand_dim();
            h = rand_dim();
            r = mf2c_pkg::RAD_W'($urandom_range(3));
            if ($urandom_range(3) != 0) reg_write(mf2c_pkg::REG_IMG_WIDTH, w);
            if ($urandom_range(3) != 0) reg_write(mf2c_pkg::REG_IMG_HEIGHT, h);
            reg_write(mf2c_pkg::REG_RADIUS, r);
            eff_w = sb.eff(sb.width_reg, mf2c_pkg::DEF_MAX_WIDTH);
            eff_h = sb.eff(sb.height_reg, mf2c_pkg::DEF_MAX_HEIGHT);
            planes = $urandom_range(2, 1);
            if (eff_w * eff_h <= 60 && $urandom_range(4) != 0)
                n_items = eff_w * eff_h * planes;
            else
                n_items = $urandom_range(40, 1);
            for (int i = 0; i < n_items; i++)
            begin
                if (!pressed && sent >= N_RANDOM / 2)
                begin
                    pressed = 1'b1;
                    hold_req = 1'b1;
                end
                send_pixel(rand_pixel());
                sent++;
            end
        end

        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
